/* sv/tsp_pkg.sv */
package tsp_pkg;

  // Packet geometry
  localparam int PAYLOAD_BYTES = 184;
  localparam int POS_W         = 8;

  // Continuity counter table, indexed by all 13 PID bits
  localparam int PID_ENTRIES = 8192;
  localparam int SLOT_W      = $clog2(PID_ENTRIES);
  localparam int CC_W        = 4;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Header constants
  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [1:0] ADAPT_CTRL = 2'b01;

  // Config reset value
  localparam logic [7:0] STUFF_RESET = 8'hFF;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // One classified section byte, optionally preceded by a header
  typedef struct packed {
    logic              has_hdr;
    logic              pusi;
    logic [12:0]       pid;
    logic [CC_W-1:0]   cc;
    logic [7:0]        data;
    logic              pend;
    logic [7:0]        stuff;
  } tsp_item_t;

endpackage

/* sv/ts_section_packetizer.sv */
// Transport-stream section packetizer.
// Input channel (push/full): one section byte per beat with its 13-bit PID
// and an end-of-section mark. Result channel (empty/pop): header beats
// (item_kind 0) and payload beats (item_kind 1); the head beat is shown
// while empty is low and taken on pop. Each packet starts with a header
// beat carrying sync, payload-unit-start, PID and the per-PID continuity
// counter; a section's last byte reports the stuffing bytes still needed.
// A byte passes through the stage 1 counter table read and then the queue
// write before it shows up. One byte per cycle goes in while full is low;
// the result side moves one beat per cycle while pop is high, and the
// 4-entry queue takes up each packet's extra header beat until it fills.
// Reset: the 8192-entry counter table is swept to zero, one entry per
// cycle; full stays high while the sweep runs. Config writes are taken
// at any time. When the receiver holds off pop the queue fills and full
// rises; nothing is dropped.
module ts_section_packetizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [12:0] packet_id,
  input  logic [7:0]  data_byte,
  input  logic        section_end,
  output logic        empty,
  input  logic        pop,
  output logic        item_kind,
  output logic [31:0] header_word,
  output logic [7:0]  payload_byte,
  output logic        packet_end,
  output logic [7:0]  stuffing_count,
  output logic        run_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]                   stuffing_value;
  logic                         q_push;
  tsp_pkg::tsp_item_t           q_item;
  logic [tsp_pkg::QCNT_W-1:0]   q_count;

  // Stuffing byte value, written by config; no output uses it
  always_ff @(posedge clk) begin
    if (rst) begin
      stuffing_value <= tsp_pkg::STUFF_RESET;
    end else if (cfg_we) begin
      stuffing_value <= cfg_wdata;
    end
  end

  tsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .packet_id   (packet_id),
    .data_byte   (data_byte),
    .section_end (section_end),
    .q_count     (q_count),
    .full        (full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  tsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_push         (q_push),
    .q_item         (q_item),
    .q_count        (q_count),
    .pop            (pop),
    .empty          (empty),
    .item_kind      (item_kind),
    .header_word    (header_word),
    .payload_byte   (payload_byte),
    .packet_end     (packet_end),
    .stuffing_count (stuffing_count),
    .run_last       (run_last)
  );

endmodule

/* sv/tsp_ram.sv */
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tsp_front.sv */
module tsp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [12:0]               packet_id,
  input  logic [7:0]                data_byte,
  input  logic                      section_end,
  input  logic [tsp_pkg::QCNT_W-1:0] q_count,
  output logic                      full,
  output logic                      q_push,
  output tsp_pkg::tsp_item_t        q_item
);

  logic                        clearing;
  logic [tsp_pkg::SLOT_W-1:0]  clr_addr;
  logic [tsp_pkg::POS_W-1:0]   pos;
  logic                        ssp;
  logic                        s1_valid;
  tsp_pkg::tsp_item_t          s1_item;
  logic [tsp_pkg::SLOT_W-1:0]  s1_slot;
  logic                        fwd_valid;
  logic [tsp_pkg::SLOT_W-1:0]  fwd_slot;
  logic [tsp_pkg::CC_W-1:0]    fwd_cc;

  logic                        accept;
  logic                        needs_hdr;
  logic [tsp_pkg::POS_W-1:0]   pos_inc;
  logic                        closes;
  logic [7:0]                  stuff;
  logic [tsp_pkg::QCNT_W:0]    occupancy;
  logic                        ram_we;
  logic [tsp_pkg::SLOT_W-1:0]  ram_waddr;
  logic [tsp_pkg::CC_W-1:0]    ram_wdata;
  logic [tsp_pkg::CC_W-1:0]    ram_rdata;
  logic [tsp_pkg::CC_W-1:0]    cc_cur;

  // Stage 1 always drains into the queue, so leave room for it
  assign occupancy = (tsp_pkg::QCNT_W+1)'(q_count) + (tsp_pkg::QCNT_W+1)'(s1_valid);
  assign full      = clearing || (occupancy >= (tsp_pkg::QCNT_W+1)'(tsp_pkg::QDEPTH));
  assign accept    = push && !full;

  // Classify the incoming byte
  assign needs_hdr = (pos == '0);
  assign pos_inc   = pos + tsp_pkg::POS_W'(1);
  assign closes    = section_end || (pos_inc >= tsp_pkg::POS_W'(tsp_pkg::PAYLOAD_BYTES));
  assign stuff     = (section_end && (pos_inc < tsp_pkg::POS_W'(tsp_pkg::PAYLOAD_BYTES))) ?
                     8'(tsp_pkg::PAYLOAD_BYTES) - 8'(pos_inc) : 8'd0;

  // Packet position and section-start flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ssp <= 1'b1;
    end else if (accept) begin
      pos <= closes ? '0 : pos_inc;
      if (section_end) begin
        ssp <= 1'b1;
      end else if (needs_hdr) begin
        ssp <= 1'b0;
      end
    end
  end

  // Table clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + tsp_pkg::SLOT_W'(1);
      if (clr_addr == tsp_pkg::SLOT_W'(tsp_pkg::PID_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage 1: counter read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_item.has_hdr <= needs_hdr;
    s1_item.pusi    <= ssp;
    s1_item.pid     <= packet_id;
    s1_item.cc      <= '0;
    s1_item.data    <= data_byte;
    s1_item.pend    <= closes;
    s1_item.stuff   <= stuff;
    s1_slot         <= packet_id[tsp_pkg::SLOT_W-1:0];
  end

  // Bypass the update written at the edge the read was issued
  assign cc_cur = (fwd_valid && (fwd_slot == s1_slot)) ? fwd_cc : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid && s1_item.has_hdr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_slot <= s1_slot;
    fwd_cc   <= cc_cur + tsp_pkg::CC_W'(1);
  end

  // Counter table write port: clear sweep or increment
  assign ram_we    = clearing || (s1_valid && s1_item.has_hdr);
  assign ram_waddr = clearing ? clr_addr : s1_slot;
  assign ram_wdata = clearing ? '0 : cc_cur + tsp_pkg::CC_W'(1);

  tsp_ram #(
    .WIDTH (tsp_pkg::CC_W),
    .DEPTH (tsp_pkg::PID_ENTRIES)
  ) u_cc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (packet_id[tsp_pkg::SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // Hand to the queue with the resolved counter
  always_comb begin
    q_item    = s1_item;
    q_item.cc = s1_item.has_hdr ? cc_cur : '0;
  end
  assign q_push = s1_valid;

endmodule

/* sv/tsp_back.sv */
module tsp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_push,
  input  tsp_pkg::tsp_item_t         q_item,
  output logic [tsp_pkg::QCNT_W-1:0] q_count,
  input  logic                       pop,
  output logic                       empty,
  output logic                       item_kind,
  output logic [31:0]                header_word,
  output logic [7:0]                 payload_byte,
  output logic                       packet_end,
  output logic [7:0]                 stuffing_count,
  output logic                       run_last
);

  tsp_pkg::tsp_item_t          entries [tsp_pkg::QDEPTH];
  logic [tsp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tsp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tsp_pkg::QCNT_W-1:0]  count;
  logic                        phase;

  tsp_pkg::tsp_item_t          head;
  logic                        hdr_beat;
  logic                        beat;
  logic                        deq;

  assign head     = entries[rd_ptr];
  assign empty    = (count == '0);
  assign hdr_beat = head.has_hdr && !phase;
  assign beat     = pop && !empty;
  assign deq      = beat && !hdr_beat;
  assign q_count  = count;

  // Queue storage
  always_ff @(posedge clk) begin
    if (q_push) begin
      entries[wr_ptr] <= q_item;
    end
  end

  // Pointers, fill count and header/payload phase
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= 1'b0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + tsp_pkg::QPTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + tsp_pkg::QPTR_W'(1);
      end
      if (q_push && !deq) begin
        count <= count + tsp_pkg::QCNT_W'(1);
      end else if (!q_push && deq) begin
        count <= count - tsp_pkg::QCNT_W'(1);
      end
      if (beat) begin
        phase <= hdr_beat;
      end
    end
  end

  // Result beat from the queue head
  always_comb begin
    if (hdr_beat) begin
      item_kind      = tsp_pkg::KIND_HEADER;
      header_word    = {tsp_pkg::SYNC_BYTE, 1'b0, head.pusi, 1'b0, head.pid,
                        2'b00, tsp_pkg::ADAPT_CTRL, head.cc};
      payload_byte   = 8'd0;
      packet_end     = 1'b0;
      stuffing_count = 8'd0;
      run_last       = 1'b0;
    end else begin
      item_kind      = tsp_pkg::KIND_PAYLOAD;
      header_word    = 32'd0;
      payload_byte   = head.data;
      packet_end     = head.pend;
      stuffing_count = head.stuff;
      run_last       = 1'b1;
    end
  end

endmodule

/* sv/tsp_checker.sv */
module tsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        item_kind,
  input logic [31:0] header_word,
  input logic        run_last
);

  // Table sweep blocks input right after reset
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  // A waiting beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn without pop");

  // A header beat is the first of two results for its byte
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (run_last == item_kind))
    else $error("run_last does not match beat kind");

  // The payload byte follows its header at once
  a_hdr_then_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && (item_kind == tsp_pkg::KIND_HEADER)) |=>
    (!empty && (item_kind == tsp_pkg::KIND_PAYLOAD)))
    else $error("header beat not followed by payload beat");

  // Every header starts with the sync byte
  a_sync: assert property (@(posedge clk) disable iff (rst)
    (!empty && (item_kind == tsp_pkg::KIND_HEADER)) |->
    (header_word[31:24] == tsp_pkg::SYNC_BYTE))
    else $error("header without sync byte");

endmodule

bind ts_section_packetizer tsp_checker u_tsp_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .item_kind   (item_kind),
  .header_word (header_word),
  .run_last    (run_last)
);
